// ----- design/fpr_pkg.sv -----
// shared widths, constants and chain types of the fuzzy path result cache
package fpr_pkg;

	localparam int unsigned ENTRIES_DEF = 10;

	localparam int DOM_W    = 16;
	localparam int COORD_W  = 16;
	localparam int CLR_W    = 16;
	localparam int MASK_W   = 8;
	localparam int HANDLE_W = 16;
	localparam int RAD_W    = 32;
	localparam int TOTAL_W  = 32;
	localparam int SQ_W     = 2 * COORD_W;

	localparam logic [RAD_W-1:0] RADIUS_SQ_RESET = 32'd57600;

	// key fields of one cache entry and of one query
	typedef struct packed {
		logic [DOM_W-1:0]          start_domain;
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic [DOM_W-1:0]          end_domain;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic [CLR_W-1:0]          clearance;
		logic [MASK_W-1:0]         obstacle_mask;
	} key_t;

	// lookup moving down the chain
	typedef struct packed {
		logic valid;
		key_t key;
	} query_t;

	// partial match result moving down the chain behind the query
	typedef struct packed {
		logic                valid;
		logic                hit;
		logic [HANDLE_W-1:0] handle;
	} res_t;

endpackage

// ----- design/fpr_cell.sv -----
// one cache entry cell: holds a key and handle, matches the passing lookup
module fpr_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          used,
	input  logic [fpr_pkg::RAD_W-1:0]     radius_sq,
	input  logic                          wr_en,
	input  fpr_pkg::key_t                 wr_key,
	input  logic [fpr_pkg::HANDLE_W-1:0]  wr_handle,
	input  fpr_pkg::query_t               q_in,
	input  fpr_pkg::res_t                 r_in,
	output fpr_pkg::query_t               q_out,
	output fpr_pkg::res_t                 r_out
);

	fpr_pkg::key_t                 key_q;
	logic [fpr_pkg::HANDLE_W-1:0]  handle_q;

	logic                          q_valid_s1;
	fpr_pkg::key_t                 q_key_s1;
	logic                          valid_s2;
	logic                          match_s2;
	logic [fpr_pkg::SQ_W-1:0]      ssx_s2;
	logic [fpr_pkg::SQ_W-1:0]      ssy_s2;
	logic [fpr_pkg::SQ_W-1:0]      esx_s2;
	logic [fpr_pkg::SQ_W-1:0]      esy_s2;
	logic                          r_valid_q;
	logic                          r_hit_q;
	logic [fpr_pkg::HANDLE_W-1:0]  r_handle_q;

	logic                          match_s1;
	logic [fpr_pkg::SQ_W:0]        start_sum;
	logic [fpr_pkg::SQ_W:0]        end_sum;
	logic                          hit_cur;

	// exact square of a 17-bit difference; its magnitude fits 16 bits
	function automatic logic [fpr_pkg::SQ_W-1:0] sq_diff(
		input logic [fpr_pkg::COORD_W-1:0] a,
		input logic [fpr_pkg::COORD_W-1:0] b
	);
		logic [fpr_pkg::COORD_W:0]   d;
		logic [fpr_pkg::COORD_W:0]   neg;
		logic [fpr_pkg::COORD_W-1:0] m;
		logic [fpr_pkg::SQ_W-1:0]    p;
		d   = {a[fpr_pkg::COORD_W-1], a} - {b[fpr_pkg::COORD_W-1], b};
		neg = -d;
		m   = d[fpr_pkg::COORD_W] ? neg[fpr_pkg::COORD_W-1:0] : d[fpr_pkg::COORD_W-1:0];
		p   = m * m;
		return p;
	endfunction

	assign match_s1 = q_valid_s1 && used
		&& (q_key_s1.start_domain == key_q.start_domain)
		&& (q_key_s1.end_domain == key_q.end_domain)
		&& (q_key_s1.obstacle_mask == key_q.obstacle_mask)
		&& (q_key_s1.clearance <= key_q.clearance);

	assign start_sum = {1'b0, ssx_s2} + {1'b0, ssy_s2};
	assign end_sum   = {1'b0, esx_s2} + {1'b0, esy_s2};
	assign hit_cur   = valid_s2 && match_s2
		&& (start_sum < (fpr_pkg::SQ_W + 1)'(radius_sq))
		&& (end_sum < (fpr_pkg::SQ_W + 1)'(radius_sq));

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_q    <= wr_key;
			handle_q <= wr_handle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_valid_s1 <= 1'b0;
			valid_s2   <= 1'b0;
			r_valid_q  <= 1'b0;
		end else begin
			q_valid_s1 <= q_in.valid;
			valid_s2   <= q_valid_s1;
			r_valid_q  <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		q_key_s1 <= q_in.key;
		match_s2 <= match_s1;
		ssx_s2   <= sq_diff(q_key_s1.start_x, key_q.start_x);
		ssy_s2   <= sq_diff(q_key_s1.start_y, key_q.start_y);
		esx_s2   <= sq_diff(q_key_s1.end_x, key_q.end_x);
		esy_s2   <= sq_diff(q_key_s1.end_y, key_q.end_y);
		// an earlier entry that matched wins
		r_hit_q  <= r_in.hit || hit_cur;
		if (r_in.hit) begin
			r_handle_q <= r_in.handle;
		end else if (hit_cur) begin
			r_handle_q <= handle_q;
		end else begin
			r_handle_q <= '0;
		end
	end

	assign q_out = {q_valid_s1, q_key_s1};
	assign r_out = {r_valid_q, r_hit_q, r_handle_q};

endmodule

// ----- design/fuzzy_path_result_cache_core.sv -----
// top level of the fuzzy path result cache: control, counters and the cell chain
//
// Each cell of a row of ENTRIES cells holds one cached key and path handle. An insert
// writes the next free cell, or the oldest one once all are used, and its result goes
// from the result state into the output register. A lookup enters the first cell and
// moves one cell per cycle, each cell squaring the point differences in one stage and
// comparing against the radius in the next, with the first match carried along; its
// result is caught at the chain end in the scan state and goes through the result state
// into the output register. One item is worked on at a time: the next item is taken
// once the result is in the output register, which keeps waiting for the downstream
// side without stalling that next item; a result that finds the output register still
// full waits until it is read. The match radius register may be written at any time the
// block is idle.
module fuzzy_path_result_cache_core #(
	parameter int unsigned ENTRIES = fpr_pkg::ENTRIES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// start_domain, start_x, start_y, end_domain, end_x, end_y, clearance,
	// obstacle_mask, path_handle
	input  logic [135:0] s_tdata,
	// mode
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// found_handle, hits_total, misses_total
	output logic [79:0]  m_tdata,
	// hit
	output logic [0:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data
);

	localparam int CNT_W = $clog2(ENTRIES + 1);
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	localparam logic MODE_LOOKUP = 1'b0;
	localparam logic MODE_INSERT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_RESULT = 3'b100
	} state_t;

	state_t                           state_q;
	logic [CNT_W-1:0]                 used_q;
	logic [IDX_W-1:0]                 oldest_q;
	logic [fpr_pkg::RAD_W-1:0]        radius_q;
	logic [fpr_pkg::TOTAL_W-1:0]      hit_cnt_q;
	logic [fpr_pkg::TOTAL_W-1:0]      miss_cnt_q;
	logic                             hold_hit_q;
	logic [fpr_pkg::HANDLE_W-1:0]     hold_handle_q;
	logic                             m_tvalid_q;
	logic [79:0]                      m_tdata_q;
	logic [0:0]                       m_tuser_q;

	logic                             in_acc;
	logic                             is_insert;
	logic                             ins_we;
	logic                             full;
	logic [IDX_W-1:0]                 slot;
	logic                             out_free;
	fpr_pkg::key_t                    in_key;
	logic [fpr_pkg::HANDLE_W-1:0]     in_handle;
	fpr_pkg::query_t                  q_chain [ENTRIES+1];
	fpr_pkg::res_t                    r_chain [ENTRIES+1];
	fpr_pkg::res_t                    tail;

	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign is_insert = (s_tuser[0] == MODE_INSERT);
	assign ins_we    = in_acc && is_insert;
	assign full      = (used_q == CNT_W'(ENTRIES));
	assign slot      = full ? oldest_q : used_q[IDX_W-1:0];
	assign out_free  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;

	assign in_key.start_domain  = s_tdata[15:0];
	assign in_key.start_x       = s_tdata[31:16];
	assign in_key.start_y       = s_tdata[47:32];
	assign in_key.end_domain    = s_tdata[63:48];
	assign in_key.end_x         = s_tdata[79:64];
	assign in_key.end_y         = s_tdata[95:80];
	assign in_key.clearance     = s_tdata[111:96];
	assign in_key.obstacle_mask = s_tdata[119:112];
	assign in_handle            = s_tdata[135:120];

	assign q_chain[0] = {in_acc && (s_tuser[0] == MODE_LOOKUP), in_key};
	assign r_chain[0] = '0;
	assign tail       = r_chain[ENTRIES];

	for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_cell
		fpr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.used      (used_q > CNT_W'(gi)),
			.radius_sq (radius_q),
			.wr_en     (ins_we && (slot == IDX_W'(gi))),
			.wr_key    (in_key),
			.wr_handle (in_handle),
			.q_in      (q_chain[gi]),
			.r_in      (r_chain[gi]),
			.q_out     (q_chain[gi+1]),
			.r_out     (r_chain[gi+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			used_q     <= '0;
			oldest_q   <= '0;
			radius_q   <= fpr_pkg::RADIUS_SQ_RESET;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				radius_q <= cfg_data;
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (is_insert) begin
							// append until full, then replace in arrival order
							if (!full) begin
								used_q <= used_q + 1'b1;
							end else if (oldest_q == IDX_W'(ENTRIES - 1)) begin
								oldest_q <= '0;
							end else begin
								oldest_q <= oldest_q + 1'b1;
							end
							state_q <= ST_RESULT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (tail.valid) begin
						if (tail.hit) begin
							hit_cnt_q <= hit_cnt_q + 1'b1;
						end else begin
							miss_cnt_q <= miss_cnt_q + 1'b1;
						end
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ins_we) begin
			hold_hit_q    <= 1'b0;
			hold_handle_q <= '0;
		end else if (state_q == ST_SCAN && tail.valid) begin
			hold_hit_q    <= tail.hit;
			hold_handle_q <= tail.handle;
		end
		if (state_q == ST_RESULT && out_free) begin
			m_tdata_q <= {miss_cnt_q, hit_cnt_q, hold_handle_q};
			m_tuser_q <= hold_hit_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// a lookup result reaches the chain end only while a scan is pending
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> state_q == ST_SCAN)
		else $error("chain result outside of a scan");

	// the query leaving the last cell belongs to the scan in progress
	a_query_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		q_chain[ENTRIES].valid |-> state_q == ST_SCAN)
		else $error("query left the chain outside of a scan");

	// replacement pointer moves only once every cell holds an entry
	a_oldest_full: assert property (@(posedge clk) disable iff (!arst_n)
		(oldest_q != '0) |-> full)
		else $error("replacement pointer moved before cache filled");

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(ENTRIES))
		else $error("entry count beyond cache size");

	// every finished lookup advances exactly one of the two counters
	a_one_counter: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && tail.valid) |=>
		((hit_cnt_q != $past(hit_cnt_q)) != (miss_cnt_q != $past(miss_cnt_q))))
		else $error("lookup counters out of step");

endmodule

// ----- verif/fuzzy_path_result_cache_core_test.sv -----
// self-checking testbench of the fuzzy path result cache core
module fuzzy_path_result_cache_core_test;

	import fpr_pkg::*;

	localparam int unsigned SLOTS = ENTRIES_DEF;

	typedef enum logic {
		MODE_LOOKUP = 1'b0,
		MODE_INSERT = 1'b1
	} mode_e;

	typedef struct packed {
		mode_e               mode;
		key_t                key;
		logic [HANDLE_W-1:0] path_handle;
	} path_req_t;

	typedef struct packed {
		logic                hit;
		logic [HANDLE_W-1:0] found_handle;
		logic [TOTAL_W-1:0]  hits_total;
		logic [TOTAL_W-1:0]  misses_total;
	} cache_result_t;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [135:0] s_tdata;
	logic [0:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [79:0]  m_tdata;
	logic [0:0]   m_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [31:0]  cfg_data;

	// cache contents as the checker sees them
	key_t                cached_keys [SLOTS];
	logic [HANDLE_W-1:0] cached_handles [SLOTS];
	int unsigned         fill_count;
	int unsigned         replace_slot;
	logic [TOTAL_W-1:0]  hit_tally;
	logic [TOTAL_W-1:0]  miss_tally;
	logic [RAD_W-1:0]    radius_sq;

	path_req_t     queued_requests[$];
	cache_result_t awaited_results[$];
	key_t          recent_keys[$];
	path_req_t     driven_req;
	bit            req_taken;
	int            send_idle_pct;
	int            recv_idle_pct;
	int            mismatch_count;

	fuzzy_path_result_cache_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic longint point_dist_sq(input logic signed [COORD_W-1:0] ax,
			input logic signed [COORD_W-1:0] ay, input logic signed [COORD_W-1:0] bx,
			input logic signed [COORD_W-1:0] by);
		longint dx;
		longint dy;
		dx = longint'(ax) - longint'(bx);
		dy = longint'(ay) - longint'(by);
		return dx * dx + dy * dy;
	endfunction

	// applies one item to the cache copy and returns the result it must produce
	function automatic cache_result_t resolve_path_query(input path_req_t req);
		cache_result_t res;
		key_t          q;
		key_t          e;
		int unsigned   slot;
		q = req.key;
		res.hit = 1'b0;
		res.found_handle = '0;
		if (req.mode == MODE_INSERT) begin
			if (fill_count < SLOTS) begin
				slot = fill_count;
				fill_count++;
			end else begin
				slot = replace_slot;
				replace_slot = (replace_slot + 1) % SLOTS;
			end
			cached_keys[slot] = q;
			cached_handles[slot] = req.path_handle;
		end else begin
			for (int i = 0; i < fill_count && !res.hit; i++) begin
				e = cached_keys[i];
				if (e.start_domain == q.start_domain && e.end_domain == q.end_domain
						&& q.clearance <= e.clearance && q.obstacle_mask == e.obstacle_mask
						&& point_dist_sq(e.start_x, e.start_y, q.start_x, q.start_y)
							< longint'(radius_sq)
						&& point_dist_sq(e.end_x, e.end_y, q.end_x, q.end_y)
							< longint'(radius_sq)) begin
					res.hit = 1'b1;
					res.found_handle = cached_handles[i];
				end
			end
			if (res.hit)
				hit_tally++;
			else
				miss_tally++;
		end
		res.hits_total = hit_tally;
		res.misses_total = miss_tally;
		return res;
	endfunction

	function automatic logic [135:0] pack_request(input path_req_t r);
		return {r.path_handle, r.key.obstacle_mask, r.key.clearance, r.key.end_y, r.key.end_x,
			r.key.end_domain, r.key.start_y, r.key.start_x, r.key.start_domain};
	endfunction

	function automatic key_t make_key(input int sdom, input int sx, input int sy, input int edom,
			input int ex, input int ey, input int clr, input int mask);
		key_t k;
		k.start_domain = 16'(sdom);
		k.start_x = 16'(sx);
		k.start_y = 16'(sy);
		k.end_domain = 16'(edom);
		k.end_x = 16'(ex);
		k.end_y = 16'(ey);
		k.clearance = 16'(clr);
		k.obstacle_mask = 8'(mask);
		return k;
	endfunction

	function automatic logic [COORD_W-1:0] jitter(input int span);
		return 16'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic key_t random_key(input int span);
		key_t k;
		if ($urandom_range(0, 9) < 3) begin
			k = make_key($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom);
		end else begin
			// keys of a few shared domains and masks, so that lookups can land on them
			k = make_key($urandom_range(0, 2), jitter(4 * span), jitter(4 * span),
				$urandom_range(0, 2), jitter(4 * span), jitter(4 * span),
				$urandom_range(0, 300), 0);
			case ($urandom_range(0, 2))
				0: k.obstacle_mask = 8'h00;
				1: k.obstacle_mask = 8'h81;
				default: k.obstacle_mask = 8'hff;
			endcase
		end
		return k;
	endfunction

	function automatic path_req_t random_request(input int span);
		path_req_t   r;
		key_t        k;
		int unsigned roll;
		roll = $urandom_range(0, 99);
		r.path_handle = 16'($urandom);
		if (roll < 35 || recent_keys.size() == 0) begin
			r.mode = MODE_INSERT;
			k = random_key(span);
			recent_keys = {recent_keys, k};
			if (recent_keys.size() > SLOTS)
				void'(recent_keys.pop_front());
		end else if (roll < 80) begin
			// near a key still in the cache: jittered by up to span per coordinate, within the radius or not
			r.mode = MODE_LOOKUP;
			k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
			k.start_x += jitter(span);
			k.start_y += jitter(span);
			k.end_x += jitter(span);
			k.end_y += jitter(span);
			if ($urandom_range(0, 4) != 0)
				k.clearance = 16'($urandom_range(0, k.clearance));
			else
				k.clearance += 16'd1;
			if ($urandom_range(0, 9) == 0)
				k.obstacle_mask ^= 8'(1 << $urandom_range(0, 7));
			if ($urandom_range(0, 19) == 0)
				k.start_domain = 16'($urandom);
			if ($urandom_range(0, 19) == 0)
				k.end_domain = 16'($urandom);
		end else begin
			r.mode = MODE_LOOKUP;
			k = random_key(span);
		end
		r.key = k;
		return r;
	endfunction

	function automatic void queue_request(input mode_e mode, input key_t k, input int handle);
		path_req_t r;
		r.mode = mode;
		r.key = k;
		r.path_handle = 16'(handle);
		queued_requests = {queued_requests, r};
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] seen,
			input logic [31:0] wanted);
		$display("%0t: %s is %0h, expected %0h", $realtime, what, seen, wanted);
		mismatch_count++;
	endtask

	// driver
	always @(negedge clk) begin
		if (s_tvalid && !req_taken) begin
			// item still waiting to be taken
		end else if (queued_requests.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
			driven_req = queued_requests.pop_front();
			s_tvalid <= 1'b1;
			s_tdata <= pack_request(driven_req);
			s_tuser <= driven_req.mode;
		end else begin
			s_tvalid <= 1'b0;
		end
		m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// monitor
	always @(posedge clk) begin
		cache_result_t got;
		cache_result_t want;
		req_taken = s_tvalid && s_tready;
		if (m_tvalid && m_tready) begin
			got.hit = m_tuser[0];
			got.found_handle = m_tdata[15:0];
			got.hits_total = m_tdata[47:16];
			got.misses_total = m_tdata[79:48];
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected item, found_handle", 32'(got.found_handle), 0);
			end else begin
				want = awaited_results.pop_front();
				if (got.hit !== want.hit)
					report_mismatch("hit", 32'(got.hit), 32'(want.hit));
				if (got.found_handle !== want.found_handle)
					report_mismatch("found_handle", 32'(got.found_handle),
						32'(want.found_handle));
				if (got.hits_total !== want.hits_total)
					report_mismatch("hits_total", got.hits_total, want.hits_total);
				if (got.misses_total !== want.misses_total)
					report_mismatch("misses_total", got.misses_total, want.misses_total);
			end
		end
		if (req_taken)
			awaited_results = {awaited_results, resolve_path_query(driven_req)};
	end

	task automatic wait_drained();
		do
			@(posedge clk);
		while (queued_requests.size() != 0 || s_tvalid || awaited_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_radius(input logic [31:0] value);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = value;
		do
			@(posedge clk);
		while (!cfg_ready);
		radius_sq = value;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic run_phase(input logic [31:0] radius, input int span, input int send_idle,
			input int recv_idle, input int count);
		wait_drained();
		send_idle_pct = send_idle;
		recv_idle_pct = recv_idle;
		write_radius(radius);
		repeat (count) queued_requests = {queued_requests, random_request(span)};
	endtask

	initial begin
		key_t ka;
		key_t kb;
		key_t k;
		int   side;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		req_taken = 1'b0;
		mismatch_count = 0;
		fill_count = 0;
		replace_slot = 0;
		hit_tally = '0;
		miss_tally = '0;
		radius_sq = RADIUS_SQ_RESET;
		send_idle_pct = 15;
		recv_idle_pct = 82;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part at the reset radius of 240 (squared radius 57600)
		ka = make_key(16'h0001, -32768, 32767, 16'h0002, 100, -100, 16'h0040, 8'h5a);
		kb = make_key(16'hffff, 32767, -32768, 16'hffff, -32768, 32767, 16'hffff, 8'hff);
		queue_request(MODE_LOOKUP, ka, 16'h0bad);                 // empty cache
		queue_request(MODE_INSERT, ka, 16'h1234);
		queue_request(MODE_LOOKUP, ka, 0);
		k = ka; k.clearance = 16'h0000;
		queue_request(MODE_LOOKUP, k, 0);
		k = ka; k.clearance = 16'h0041;                           // needs more clearance
		queue_request(MODE_LOOKUP, k, 0);
		k = ka; k.start_x += 16'sd239;                            // just inside the radius
		queue_request(MODE_LOOKUP, k, 0);
		k = ka; k.end_y += 16'sd240;                              // exactly on the radius
		queue_request(MODE_LOOKUP, k, 0);
		k = ka; k.end_x -= 16'sd170; k.end_y += 16'sd169;
		queue_request(MODE_LOOKUP, k, 0);
		k = ka; k.obstacle_mask ^= 8'h80;
		queue_request(MODE_LOOKUP, k, 0);
		k = ka; k.start_domain ^= 16'h0001;
		queue_request(MODE_LOOKUP, k, 0);
		k = ka; k.end_domain ^= 16'h8000;
		queue_request(MODE_LOOKUP, k, 0);
		queue_request(MODE_INSERT, kb, 16'hffff);
		k = make_key(16'hffff, -32768, 32767, 16'hffff, 32767, -32768, 16'hffff, 8'hff);
		queue_request(MODE_LOOKUP, k, 0);                         // farthest possible points
		queue_request(MODE_LOOKUP, kb, 0);
		queue_request(MODE_INSERT, ka, 16'hbeef);                 // duplicate key, first wins
		queue_request(MODE_LOOKUP, ka, 0);
		// fill the cache and overwrite the oldest slot
		for (int i = 0; i < 8; i++)
			queue_request(MODE_INSERT, make_key(0, 0, 0, 0, 0, 0, 0, 0), i);
		queue_request(MODE_LOOKUP, ka, 0);

		run_phase(32'd0, 10, 15, 82, 40);
		run_phase(32'd57600, 240, 82, 15, 150);
		run_phase(32'hffff_ffff, 20000, 82, 15, 60);
		side = $urandom_range(1, 400);
		run_phase(32'(side * side), side, 0, 0, 120);
		run_phase(32'd1, 1, 0, 0, 60);

		wait_drained();
		repeat (SLOTS + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("fuzzy_path_result_cache_core_test: clean");
		else
			$display("fuzzy_path_result_cache_core_test: errors");
		$finish;
	end

	initial begin
		#(12 * 400000);
		$display("fuzzy_path_result_cache_core_test: errors");
		$finish;
	end

endmodule

// ----- files.f -----
design/fpr_pkg.sv
design/fpr_cell.sv
design/fuzzy_path_result_cache_core.sv
verif/fuzzy_path_result_cache_core_test.sv
